### src/sfsl_pkg.sv
// sfsl_pkg: shared widths, command and status codes, and the types passed
// between the sorted slot list top level and its cells
// no dependencies
package sfsl_pkg;

    localparam int ID_W         = 32;
    localparam int SIZE_W       = 48;
    localparam int OCC_W        = 7;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int DEF_CAPACITY = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 2'd0,
        CMD_POP_MAX = 2'd1,
        CMD_POP_MIN = 2'd2,
        CMD_REMOVE  = 2'd3
    } t_cmd;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // one held slot
    typedef struct packed {
        logic              valid;
        logic [ID_W-1:0]   id;
        logic [SIZE_W-1:0] size;
    } t_entry;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic cmp;     // compare phase: cells latch their hit flag
        logic apply;   // update phase: cells shift or load
        t_cmd cmd;
        logic ins_ok;  // insert allowed (table not full)
    } t_ctl;

endpackage

### src/sfsl_cell.sv
// sfsl_cell: one position of the sorted slot chain, holds one entry and a hit flag
// depends on sfsl_pkg
module sfsl_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfsl_pkg::t_ctl              i_ctl,
    input  logic [sfsl_pkg::ID_W-1:0]   i_id,
    input  logic [sfsl_pkg::SIZE_W-1:0] i_size,
    input  sfsl_pkg::t_entry            i_prev,   // neighbor toward the largest end
    input  sfsl_pkg::t_entry            i_next,   // neighbor toward the smallest end
    input  logic                        i_found,  // a hit lies before this cell
    output logic                        o_found,  // a hit lies here or before
    output sfsl_pkg::t_entry            o_entry,
    output sfsl_pkg::t_entry            o_pick    // own entry if taken out, else zero
);
    import sfsl_pkg::*;

    logic              r_valid;
    logic [ID_W-1:0]   r_id;
    logic [SIZE_W-1:0] r_size;
    logic              r_hit;

    logic              n_valid;
    logic [ID_W-1:0]   n_id;
    logic [SIZE_W-1:0] n_size;
    logic              n_hit;
    logic              w_take;
    logic              w_incl;

    assign o_entry = '{valid: r_valid, id: r_id, size: r_size};
    assign w_incl  = i_found | r_hit;
    assign o_found = w_incl;
    assign w_take  = r_hit & ~i_found;

    always_comb begin
        n_hit = r_hit;
        if (i_ctl.cmp) begin
            unique case (i_ctl.cmd)
                // new entry goes ahead of this one
                CMD_INSERT:  n_hit = ~r_valid || (i_size > r_size) ||
                                     (i_size == '0 && r_size == '0);
                CMD_POP_MAX: n_hit = r_valid;
                CMD_POP_MIN: n_hit = r_valid & ~i_next.valid;
                CMD_REMOVE:  n_hit = r_valid && (r_id == i_id);
                default:     n_hit = 1'b0;
            endcase
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_size  = r_size;
        if (i_ctl.apply) begin
            if (i_ctl.cmd == CMD_INSERT) begin
                if (i_ctl.ins_ok) begin
                    if (w_take) begin
                        n_valid = 1'b1;
                        n_id    = i_id;
                        n_size  = i_size;
                    end else if (i_found) begin
                        n_valid = i_prev.valid;
                        n_id    = i_prev.id;
                        n_size  = i_prev.size;
                    end
                end
            end else if (w_incl) begin
                // close the gap left by the removed entry
                n_valid = i_next.valid;
                n_id    = i_next.id;
                n_size  = i_next.size;
            end
        end
    end

    always_comb begin
        o_pick = '0;
        if (w_take && i_ctl.cmd != CMD_INSERT) begin
            o_pick = o_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hit   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_size <= n_size;
    end

endmodule

### src/sorted_free_slot_list.sv
// sorted_free_slot_list: (id, size) table kept largest first in a chain of cells
// depends on sfsl_pkg and sfsl_cell
//
//   channel   handshake                 fields
//   command   i_start / o_busy          i_cmd, i_entry_id, i_entry_size
//   result    o_strobe (no back-press)  o_status, o_out_id, o_out_size, o_occupancy
//
// a word accepted at an edge with i_start high and o_busy low is compared in every
// cell in the compare state and applied in the apply state; the result strobe is a
// one-cycle pulse that follows the apply state; o_busy is high in the compare and
// apply states; a new command can be accepted at the edge ending the strobe cycle.
// reset is synchronous and empties the table; the result side cannot stall.
module sorted_free_slot_list #(
    parameter int CAPACITY = sfsl_pkg::DEF_CAPACITY
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [sfsl_pkg::CMD_W-1:0]    i_cmd,
    input  logic [sfsl_pkg::ID_W-1:0]     i_entry_id,
    input  logic [sfsl_pkg::SIZE_W-1:0]   i_entry_size,
    output logic                          o_strobe,
    output logic [sfsl_pkg::STATUS_W-1:0] o_status,
    output logic [sfsl_pkg::ID_W-1:0]     o_out_id,
    output logic [sfsl_pkg::SIZE_W-1:0]   o_out_size,
    output logic [sfsl_pkg::OCC_W-1:0]    o_occupancy
);
    import sfsl_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_APPLY
    } t_state;

    t_state              r_state;
    t_cmd                r_cmd;
    logic [ID_W-1:0]     r_id;
    logic [SIZE_W-1:0]   r_size;
    logic [CNT_W-1:0]    r_count;
    logic                r_strobe;
    logic [STATUS_W-1:0] r_status;
    logic [ID_W-1:0]     r_out_id;
    logic [SIZE_W-1:0]   r_out_size;
    logic [OCC_W-1:0]    r_occ;

    logic [CNT_W-1:0]       n_count;
    logic [STATUS_W-1:0]    n_status;
    logic [CNT_W+OCC_W-1:0] w_occ_ext;

    t_ctl             w_ctl;
    t_entry           w_ent  [CAPACITY];
    t_entry           w_pick [CAPACITY];
    logic [CAPACITY:0] w_found;
    t_entry           w_sel;
    logic             w_any;

    assign o_busy      = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_status    = r_status;
    assign o_out_id    = r_out_id;
    assign o_out_size  = r_out_size;
    assign o_occupancy = r_occ;

    assign w_ctl.cmp    = (r_state == S_CMP);
    assign w_ctl.apply  = (r_state == S_APPLY);
    assign w_ctl.cmd    = r_cmd;
    assign w_ctl.ins_ok = (r_count != CNT_W'(CAPACITY));

    assign w_found[0] = 1'b0;

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        if (k == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_mid_prev
            assign w_prev = w_ent[k-1];
        end
        if (k == CAPACITY - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_mid_next
            assign w_next = w_ent[k+1];
        end

        sfsl_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_id    (r_id),
            .i_size  (r_size),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .i_found (w_found[k]),
            .o_found (w_found[k+1]),
            .o_entry (w_ent[k]),
            .o_pick  (w_pick[k])
        );
    end

    assign w_any = w_found[CAPACITY];

    // at most one cell offers its entry
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_sel = w_sel | w_pick[k];
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (r_cmd == CMD_INSERT) begin
            if (w_ctl.ins_ok) begin
                n_count = r_count + 1'b1;
            end else begin
                n_status = ST_FULL;
            end
        end else if (w_any) begin
            n_count = r_count - 1'b1;
        end else begin
            n_status = ST_MISS;
        end
    end

    assign w_occ_ext = {{OCC_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: begin
                    r_state <= S_APPLY;
                end
                S_APPLY: begin
                    r_state  <= S_IDLE;
                    r_count  <= n_count;
                    r_strobe <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_start) begin
            r_cmd  <= t_cmd'(i_cmd);
            r_id   <= i_entry_id;
            r_size <= i_entry_size;
        end
        if (r_state == S_APPLY) begin
            r_status   <= n_status;
            r_out_id   <= w_sel.id;
            r_out_size <= w_sel.size;
            r_occ      <= w_occ_ext[OCC_W-1:0];
        end
    end

endmodule
